// File: src/ips_patch_stream_parser_macros.svh
// Assertion macros shared by the IPS patch parser RTL.
// No dependencies; files that check their own logic include this header.
`ifndef IPS_PATCH_STREAM_PARSER_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define IPSP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ipsp assertion failed");

// Condition that must never be true outside reset
`define IPSP_NEVER(label, clk, rstn, expr) \
    `IPSP_ASSERT(label, clk, rstn, !(expr))

`else

`define IPSP_ASSERT(label, clk, rstn, prop)
`define IPSP_NEVER(label, clk, rstn, expr)

`endif

`endif

// File: src/ipsp_pkg.sv
// Types and constants for the IPS patch stream parser.
// No dependencies; used by every RTL file of the block.
package ipsp_pkg;

    // Result queue depth; must be at least 2 (one byte can cause two words)
    localparam int unsigned RESULT_FIFO_DEPTH = 4;

    // Offset value that ends the record list ("EOF")
    localparam logic [23:0] EOF_MARK = 24'h454F46;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_OK    = 2'd2,
        KIND_FAIL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_HEADER = 3'd1,
        ERR_ENDED      = 3'd2,
        ERR_ZERO_RUN   = 3'd3,
        ERR_BAD_TAIL   = 3'd4
    } err_code_t;

    // Input word
    typedef struct packed {
        logic [7:0] patch_byte;
        logic       last_byte;
    } in_word_t;

    // Result word
    typedef struct packed {
        kind_t       kind;
        logic [23:0] address;
        logic [15:0] run_length;
        logic [7:0]  fill_value;
        logic [24:0] image_length;
        err_code_t   error_code;
        logic        result_last;
    } out_word_t;

    // Expected header text "PATCH", one character per index
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h41;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h43;
            3'd4:    c = 8'h48;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: src/ipsp_parser.sv
// Byte-level parser state and next-state logic for IPS patches.
// Depends on ipsp_pkg and the assertion macro header.
`include "ips_patch_stream_parser_macros.svh"

module ipsp_parser
    import ipsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [23:0]  cfg_data,
    input  logic         in_accept,
    input  in_word_t     in_word,
    output logic [1:0]   push_cnt,
    output out_word_t    push_data [2]
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OFFSET,
        PH_SIZE,
        PH_DATA,
        PH_RUNLEN,
        PH_RUNVAL,
        PH_TAIL,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  idx_reg,    idx_next;
    logic [23:0] offset_reg, offset_next;
    logic [15:0] size_reg,   size_next;
    logic [24:0] wp_reg,     wp_next;
    logic [24:0] len_reg,    len_next;
    logic [23:0] tail_reg,   tail_next;
    err_code_t   pend_reg,   pend_next;
    logic [23:0] init_len_reg;

    logic [7:0]  b;
    logic [24:0] wp_inc;
    logic [24:0] run_end;
    err_code_t   err;
    err_code_t   code;
    logic        cmd_valid;
    out_word_t   cmd;
    out_word_t   stat;

    assign b       = in_word.patch_byte;
    assign wp_inc  = wp_reg + 25'd1;
    assign run_end = {1'b0, offset_reg} + {9'd0, size_reg};

    // Next state for one byte, plus the command and status words it causes
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        offset_next = offset_reg;
        size_next   = size_reg;
        wp_next     = wp_reg;
        len_next    = len_reg;
        tail_next   = tail_reg;
        pend_next   = pend_reg;
        err         = ERR_NONE;
        cmd_valid   = 1'b0;
        cmd         = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (idx_reg == 3'd0) begin
                    len_next = {1'b0, init_len_reg};
                end
                if (idx_reg > 3'd4 || b != hdr_char(idx_reg)) begin
                    err = ERR_BAD_HEADER;
                end else if (idx_reg == 3'd4) begin
                    phase_next  = PH_OFFSET;
                    idx_next    = '0;
                    offset_next = '0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_OFFSET: begin
                offset_next = {offset_reg[15:0], b};
                if (idx_reg == 3'd2) begin
                    idx_next = '0;
                    if (offset_next == EOF_MARK) begin
                        phase_next = PH_TAIL;
                        tail_next  = '0;
                    end else begin
                        phase_next = PH_SIZE;
                        size_next  = '0;
                    end
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_SIZE: begin
                size_next = {size_reg[7:0], b};
                if (idx_reg == 3'd1) begin
                    idx_next = '0;
                    if (size_next == 16'd0) begin
                        phase_next = PH_RUNLEN;
                    end else begin
                        phase_next = PH_DATA;
                        wp_next    = {1'b0, offset_reg};
                    end
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_DATA: begin
                if (len_reg < wp_inc) begin
                    len_next = wp_inc;
                end
                cmd_valid      = 1'b1;
                cmd.kind       = KIND_WRITE;
                cmd.address    = wp_reg[23:0];
                cmd.fill_value = b;
                wp_next        = wp_inc;
                size_next      = size_reg - 16'd1;
                if (size_reg == 16'd1) begin
                    phase_next  = PH_OFFSET;
                    idx_next    = '0;
                    offset_next = '0;
                end
            end
            PH_RUNLEN: begin
                size_next = {size_reg[7:0], b};
                if (idx_reg == 3'd1) begin
                    idx_next = '0;
                    if (size_next == 16'd0) begin
                        err = ERR_ZERO_RUN;
                    end else begin
                        phase_next = PH_RUNVAL;
                    end
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_RUNVAL: begin
                if (len_reg < run_end) begin
                    len_next = run_end;
                end
                cmd_valid      = 1'b1;
                cmd.kind       = KIND_FILL;
                cmd.address    = offset_reg;
                cmd.run_length = size_reg;
                cmd.fill_value = b;
                phase_next     = PH_OFFSET;
                idx_next       = '0;
                offset_next    = '0;
            end
            PH_TAIL: begin
                if (idx_reg < 3'd3) begin
                    tail_next = {tail_reg[15:0], b};
                    idx_next  = idx_reg + 3'd1;
                end else begin
                    err = ERR_BAD_TAIL;
                end
            end
            PH_ERROR: begin
                // bytes are dropped until the last one
            end
        endcase

        // First error wins; parser parks until end of stream
        if (err != ERR_NONE) begin
            if (pend_reg == ERR_NONE) begin
                pend_next = err;
            end
            phase_next = PH_ERROR;
        end

        // End-of-stream status, then a fresh stream
        code = pend_next;
        stat = '0;
        if (in_word.last_byte) begin
            if (code == ERR_NONE) begin
                if (phase_next == PH_TAIL) begin
                    if (idx_next == 3'd3) begin
                        len_next = {1'b0, tail_next};
                    end else if (idx_next != 3'd0) begin
                        code = ERR_BAD_TAIL;
                    end
                end else begin
                    code = ERR_ENDED;
                end
            end
            stat.kind        = (code == ERR_NONE) ? KIND_OK : KIND_FAIL;
            stat.error_code  = code;
            phase_next  = PH_HEADER;
            idx_next    = '0;
            offset_next = '0;
            size_next   = '0;
            wp_next     = '0;
            tail_next   = '0;
            pend_next   = ERR_NONE;
        end
        cmd.image_length  = len_next;
        stat.image_length = len_next;

        // Words handed to the result queue
        push_data[0] = '0;
        push_data[1] = '0;
        push_cnt     = 2'd0;
        if (in_accept) begin
            if (cmd_valid) begin
                push_data[0] = cmd;
                if (in_word.last_byte) begin
                    push_data[1]             = stat;
                    push_data[1].result_last = 1'b1;
                    push_cnt                 = 2'd2;
                end else begin
                    push_data[0].result_last = 1'b1;
                    push_cnt                 = 2'd1;
                end
            end else if (in_word.last_byte) begin
                push_data[0]             = stat;
                push_data[0].result_last = 1'b1;
                push_cnt                 = 2'd1;
            end
        end
    end

    // Parser state and configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            offset_reg   <= '0;
            size_reg     <= '0;
            wp_reg       <= '0;
            len_reg      <= '0;
            tail_reg     <= '0;
            pend_reg     <= ERR_NONE;
            init_len_reg <= '0;
        end else begin
            if (cfg_we) begin
                init_len_reg <= cfg_data;
            end
            if (in_accept) begin
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                offset_reg <= offset_next;
                size_reg   <= size_next;
                wp_reg     <= wp_next;
                len_reg    <= len_next;
                tail_reg   <= tail_next;
                pend_reg   <= pend_next;
            end
        end
    end

    // A kept error and the parked phase always go together
    `IPSP_ASSERT(a_err_parked, aclk, aresetn, (pend_reg != ERR_NONE) == (phase_reg == PH_ERROR))
    // A pair of words is always a command followed by a status word
    `IPSP_NEVER(a_pair_order, aclk, aresetn, (push_cnt == 2'd2) && ((push_data[0].kind == KIND_OK) || (push_data[0].kind == KIND_FAIL) || push_data[0].result_last))

endmodule

// File: src/ipsp_result_fifo.sv
// Small result queue that takes up to two words per cycle and gives one.
// Depends on ipsp_pkg and the assertion macro header.
`include "ips_patch_stream_parser_macros.svh"

module ipsp_result_fifo
    import ipsp_pkg::*;
#(
    parameter int unsigned DEPTH = RESULT_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  out_word_t  push_data [2],
    output logic       room_two,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    out_word_t        mem [DEPTH];
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] wr_plus1;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    assign m_valid  = (cnt_reg != '0);
    assign m_data   = mem[rd_reg];
    assign pop      = m_valid && m_ready;
    assign room_two = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign wr_plus1 = wrap_inc(wr_reg);

    // Pointer and fill count update
    always_comb begin
        rd_next = pop ? wrap_inc(rd_reg) : rd_reg;
        unique case (push_cnt)
            2'd0:    wr_next = wr_reg;
            2'd1:    wr_next = wr_plus1;
            default: wr_next = wrap_inc(wr_plus1);
        endcase
        cnt_next = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage, up to two writes per cycle
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2) begin
            mem[wr_plus1] <= push_data[1];
        end
    end

    // Fill count stays within the queue
    `IPSP_NEVER(a_no_overflow, aclk, aresetn, cnt_reg > CNT_W'(DEPTH))
    // After any push the output is valid in the next cycle
    `IPSP_ASSERT(a_push_shows, aclk, aresetn, (push_cnt != 2'd0) |=> m_valid)

endmodule

// File: src/ips_patch_stream_parser.sv
// IPS patch stream parser: one patch byte per cycle in while s_ready is high,
// command/status words out. Result words leave the result queue one at a time,
// each once the words queued before it have been taken. The last byte of a stream
// that also completes a write or fill gives two words at once into the queue.
// s_ready is high while the result queue has room for two words.
// Reset (synchronous, aresetn low): parser expects a header, lengths zero, queue empty.
module ips_patch_stream_parser
    import ipsp_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = RESULT_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: initial image length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    // patch byte words
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    logic       room_two;
    logic       in_accept;
    logic [1:0] push_cnt;
    out_word_t  push_data [2];

    assign cfg_ready = 1'b1;
    assign s_ready   = room_two;
    assign in_accept = s_valid && room_two;

    ipsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_word   (s_data),
        .push_cnt  (push_cnt),
        .push_data (push_data)
    );

    ipsp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .room_two  (room_two),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
